[sv/aes_pkg.sv]
package aes_pkg;

  localparam int ROUNDS  = 10;
  localparam int RK_ROWS = ROUNDS + 1;
  localparam int CNT_W   = 4;
  localparam int IDX_W   = 2;

  localparam logic [IDX_W-1:0] CFG_KEY_HIGH = 2'd0;
  localparam logic [IDX_W-1:0] CFG_KEY_LOW  = 2'd1;

  typedef struct packed {
    logic        kind;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_word_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_word_t;

  typedef struct packed {
    logic             we;
    logic [CNT_W-1:0] addr;
    logic [127:0]     data;
  } rk_write_t;

  localparam logic [0:255][7:0] SBOX = {
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [0:255][7:0] INV_SBOX = {
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] aa;
    p  = 8'h00;
    aa = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ aa;
      aa = xtime(aa);
    end
    return p;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // byte 0 of the state sits in the top bits
  function automatic logic [127:0] sub_bytes(input logic [127:0] x, input logic inv);
    logic [127:0] y;
    y = '0;
    for (int i = 0; i < 16; i++) begin
      y[127-8*i -: 8] = inv ? INV_SBOX[x[127-8*i -: 8]] : SBOX[x[127-8*i -: 8]];
    end
    return y;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] x, input logic inv);
    logic [127:0] y;
    int src;
    int dst;
    y = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (inv) begin
          dst = r + 4 * ((c + r) % 4);
          src = r + 4 * c;
        end else begin
          dst = r + 4 * c;
          src = r + 4 * ((c + r) % 4);
        end
        y[127-8*dst -: 8] = x[127-8*src -: 8];
      end
    end
    return y;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] x, input logic inv);
    logic [0:3][7:0] m;
    logic [127:0]    y;
    logic [7:0]      acc;
    m = inv ? {8'd14, 8'd11, 8'd13, 8'd9} : {8'd2, 8'd3, 8'd1, 8'd1};
    y = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++) begin
          acc = acc ^ gmul(x[127-8*(4*c+k) -: 8], m[(k - r + 4) % 4]);
        end
        y[127-8*(4*c+r) -: 8] = acc;
      end
    end
    return y;
  endfunction

endpackage

[sv/aes_key_expand.sv]
module aes_key_expand
  import aes_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         kick,
  input  logic [127:0] key,
  output rk_write_t    wr,
  output logic         busy
);

  logic             active;
  logic [CNT_W-1:0] row;
  logic [127:0]     cur;
  logic [7:0]       rcon;
  logic [127:0]     cur_next;
  logic [31:0]      t;
  logic [31:0]      n0, n1, n2, n3;

  // one schedule row per cycle: four words chained through the rotated, substituted last word
  always_comb begin
    t  = sub_word({cur[23:0], cur[31:24]}) ^ {rcon, 24'h0};
    n0 = cur[127:96] ^ t;
    n1 = cur[95:64] ^ n0;
    n2 = cur[63:32] ^ n1;
    n3 = cur[31:0] ^ n2;
    cur_next = {n0, n1, n2, n3};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b1;
      row    <= '0;
      cur    <= '0;
      rcon   <= 8'h01;
    end else if (kick) begin
      active <= 1'b1;
      row    <= '0;
      cur    <= key;
      rcon   <= 8'h01;
    end else if (active) begin
      cur  <= cur_next;
      rcon <= xtime(rcon);
      row  <= row + 1'b1;
      if (row == CNT_W'(ROUNDS)) active <= 1'b0;
    end
  end

  assign wr.we   = active & ~kick;
  assign wr.addr = row;
  assign wr.data = cur;
  assign busy    = active | kick;

endmodule

[sv/aes_round.sv]
module aes_round
  import aes_pkg::*;
(
  input  logic [127:0] state,
  input  logic [127:0] rk,
  input  logic         decrypt,
  input  logic         first,
  input  logic         last,
  output logic [127:0] state_next
);

  logic [127:0] sb;
  logic [127:0] fwd_core;
  logic [127:0] inv_core;

  always_comb begin
    sb       = decrypt ? sub_bytes(shift_rows(state, 1'b1), 1'b1)
                       : shift_rows(sub_bytes(state, 1'b0), 1'b0);
    fwd_core = last ? sb : mix_columns(sb, 1'b0);
    inv_core = last ? (sb ^ rk) : mix_columns(sb ^ rk, 1'b1);
    if (first) begin
      state_next = state ^ rk;
    end else if (decrypt) begin
      state_next = inv_core;
    end else begin
      state_next = fwd_core ^ rk;
    end
  end

endmodule

[sv/aes128_block_cipher_unit.sv]
// AES-128 ECB unit: one 128-bit word in, one word out, encrypt or decrypt per word.
// A new word is accepted only once the previous one is finished; the initial key add and ten rounds
// each go through the shared round unit, gated by the registered read of the round-key memory.
// Reset (synchronous, active high) clears the key and runs the key expansion; busy stays high
// until it ends. A key write reruns the expansion likewise. The receiver cannot stall.
module aes128_block_cipher_unit
  import aes_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  in_word_t         din,
  output logic             done,
  output out_word_t        dout,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [63:0]      cfg_data
);

  logic [63:0]      key_high;
  logic [63:0]      key_low;
  logic [127:0]     key_next;
  logic             key_kick;
  rk_write_t        rk_wr;
  logic             exp_busy;

  // round-key memory: one row of four words for the initial key add and for each round
  logic [127:0]     rk_mem [RK_ROWS];
  logic [127:0]     rk_q;
  logic [CNT_W-1:0] raddr;

  logic             run;
  logic             decrypt;
  logic [CNT_W-1:0] step;
  logic [127:0]     state;
  logic [127:0]     state_next;
  logic             accept;

  // merge a key write into the key the expansion starts from, so it sees the new value
  always_comb begin
    key_next = {key_high, key_low};
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_HIGH: key_next[127:64] = cfg_data;
        CFG_KEY_LOW:  key_next[63:0]   = cfg_data;
        default: ;
      endcase
    end
  end

  // hold the key registers; a write to either one restarts the expansion
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else begin
      key_high <= key_next[127:64];
      key_low  <= key_next[63:0];
    end
  end

  assign key_kick = cfg_we & ((cfg_index == CFG_KEY_HIGH) | (cfg_index == CFG_KEY_LOW));

  aes_key_expand u_expand (
    .clk  (clk),
    .rst  (rst),
    .kick (key_kick),
    .key  (key_next),
    .wr   (rk_wr),
    .busy (exp_busy)
  );

  assign busy   = exp_busy | run;
  assign accept = start & ~busy;

  // issue the read in the cycle before the round that consumes it
  always_comb begin
    if (!run) begin
      raddr = din.kind ? CNT_W'(ROUNDS) : '0;
    end else if (step == CNT_W'(ROUNDS)) begin
      raddr = '0;
    end else if (decrypt) begin
      raddr = CNT_W'(ROUNDS - 1) - step;
    end else begin
      raddr = step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rk_wr.we) rk_mem[rk_wr.addr] <= rk_wr.data;
    rk_q <= rk_mem[raddr];
  end

  aes_round u_round (
    .state      (state),
    .rk         (rk_q),
    .decrypt    (decrypt),
    .first      (step == '0),
    .last       (step == CNT_W'(ROUNDS)),
    .state_next (state_next)
  );

  // sequencer: load, then initial key add and ten rounds, then drop the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (accept) begin
        run  <= 1'b1;
        step <= '0;
      end else if (run) begin
        step <= step + 1'b1;
        if (step == CNT_W'(ROUNDS)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      state   <= {din.block_high, din.block_low};
      decrypt <= din.kind;
    end else if (run) begin
      state <= state_next;
    end
    if (run && step == CNT_W'(ROUNDS)) begin
      dout <= {state_next[127:64], state_next[63:0]};
    end
  end

endmodule
